@@ design/scc_pkg.sv @@
// Shared types and codes for the strongly connected components core.
// Used by scc_front, scc_queue, scc_back and the top level; no dependencies.
package scc_pkg;

   localparam int OP_W  = 3;
   localparam int VTX_W = 9;
   localparam int IDX_W = 10;
   localparam int STS_W = 2;

   localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
   localparam logic [OP_W-1:0] OP_COMPUTE = 3'd1;
   localparam logic [OP_W-1:0] OP_QVERT   = 3'd2;
   localparam logic [OP_W-1:0] OP_QEDGE   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

   localparam logic [VTX_W-1:0] VCOUNT_RESET = 9'd256;

   typedef enum logic [2:0] {
      K_ADD, K_COMPUTE, K_QVERT, K_QEDGE, K_CLEAR, K_NOP
   } kind_type;

   // classified transaction handed from front to back
   typedef struct packed {
      kind_type           kind;
      logic               bad_vertex;
      logic [VTX_W-1:0]   src;
      logic [VTX_W-1:0]   dst;
      logic [IDX_W-1:0]   idx;
   } item_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_ADD2, S_ADD3, S_QV, S_QE1, S_QE2, S_QE3,
      S_CSWEEP, S_ROOT, S_ROOTCHK, S_ENTER, S_STEP, S_EDGE, S_VIS,
      S_POPD, S_RET, S_RET2, S_CLRSWEEP
   } state_type;

endpackage

@@ design/scc_front.sv @@
// Front end: vertex_count register, op decode and vertex range checks.
// Depends on scc_pkg.
module scc_front #(
   parameter int MAX_VERTICES = 256,
   parameter int VVW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [scc_pkg::VTX_W-1:0]     csr_write_data,
   input  logic [scc_pkg::OP_W-1:0]      req_op,
   input  logic [scc_pkg::VTX_W-1:0]     req_source_vertex,
   input  logic [scc_pkg::VTX_W-1:0]     req_target_vertex,
   input  logic [scc_pkg::IDX_W-1:0]     req_edge_index,
   output scc_pkg::item_type             item,
   output logic [VVW-1:0]                active_n
);
   import scc_pkg::*;

   logic [VTX_W-1:0] vcount_ff, vcount_in;
   logic src_ok, dst_ok;

   always_comb begin
      vcount_in = csr_write_enable ? csr_write_data : vcount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // saturate to the vertex store size
   assign active_n = (32'(vcount_ff) > MAX_VERTICES) ? VVW'(MAX_VERTICES) : VVW'(vcount_ff);
   assign src_ok = (req_source_vertex != '0) && (32'(req_source_vertex) <= 32'(active_n));
   assign dst_ok = (req_target_vertex != '0) && (32'(req_target_vertex) <= 32'(active_n));

   always_comb begin
      item.src = req_source_vertex;
      item.dst = req_target_vertex;
      item.idx = req_edge_index;
      item.bad_vertex = 1'b0;
      case (req_op)
         OP_ADD: begin
            item.kind = K_ADD;
            item.bad_vertex = !(src_ok && dst_ok);
         end
         OP_COMPUTE: item.kind = K_COMPUTE;
         OP_QVERT: begin
            item.kind = K_QVERT;
            item.bad_vertex = !src_ok;
         end
         OP_QEDGE: item.kind = K_QEDGE;
         OP_CLEAR: item.kind = K_CLEAR;
         default:  item.kind = K_NOP;
      endcase
   end

endmodule

@@ design/scc_queue.sv @@
// Two-entry queue of classified transactions between front and back.
// Depends on scc_pkg.
module scc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scc_pkg::item_type push_item,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output scc_pkg::item_type head_item
);
   import scc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ design/scc_back.sv @@
// Back end: edge store, Tarjan sequencer with explicit stacks, queries
// and the result register. Depends on scc_pkg.
module scc_back #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024,
   parameter int VVW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  scc_pkg::item_type             q_item,
   output logic                          q_pop,
   input  logic [VVW-1:0]                active_n,
   output logic                          init_done,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scc_pkg::STS_W-1:0]     rsp_status,
   output logic [scc_pkg::VTX_W-1:0]     rsp_component,
   output logic [scc_pkg::VTX_W-1:0]     rsp_from_component,
   output logic [scc_pkg::VTX_W-1:0]     rsp_to_component,
   output logic                          rsp_crosses,
   output logic [scc_pkg::VTX_W-1:0]     rsp_component_count
);
   import scc_pkg::*;

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int LW  = $clog2(MAX_EDGES + 1);
   localparam int RW  = $clog2(MAX_VERTICES + 2);
   localparam int FW  = VAW + LW + 2 * VVW;

   // memories
   logic [VVW-1:0] etgt_mem [MAX_EDGES];
   logic [VVW-1:0] esrc_mem [MAX_EDGES];
   logic [LW-1:0]  elnk_mem [MAX_EDGES];
   logic [LW-1:0]  head_mem [MAX_VERTICES];
   logic [LW-1:0]  tail_mem [MAX_VERTICES];
   logic [VVW-1:0] visit_mem [MAX_VERTICES];
   logic [VVW-1:0] comp_mem [MAX_VERTICES];
   logic [VAW-1:0] pend_mem [MAX_VERTICES];
   logic [FW-1:0]  frame_mem [MAX_VERTICES];

   logic [VVW-1:0] etgt_rd_ff, esrc_rd_ff, visit_rd_ff, comp_rd_ff;
   logic [LW-1:0]  elnk_rd_ff, head_rd_ff, tail_rd_ff;
   logic [VAW-1:0] pend_rd_ff;
   logic [FW-1:0]  frame_rd_ff;

   logic           edge_we, elnk_we, head_we, tail_we, visit_we, comp_we, pend_we, frame_we;
   logic           edge_re, vtx_re_head, vtx_re_visit, vtx_re_comp, pend_re, frame_re;
   logic [EAW-1:0] edge_wa, elnk_wa, edge_ra;
   logic [VAW-1:0] head_wa, visit_wa, comp_wa, vtx_ra, pend_wa, pend_ra, frame_wa, frame_ra;
   logic [VVW-1:0] etgt_wd, esrc_wd, visit_wd, comp_wd;
   logic [LW-1:0]  elnk_wd, head_wd;
   logic [VAW-1:0] pend_wd;
   logic [FW-1:0]  frame_wd;

   // control registers
   state_type      state_ff, state_in;
   item_type       cur_ff, cur_in;
   logic [VAW-1:0] sw_ff, sw_in, ent_ff, ent_in;
   logic [LW-1:0]  etotal_ff, etotal_in;
   logic [VVW-1:0] ts_ff, ts_in, found_ff, found_in, pdepth_ff, pdepth_in;
   logic [VVW-1:0] fdepth_ff, fdepth_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [VAW-1:0] top_v_ff, top_v_in;
   logic [LW-1:0]  top_link_ff, top_link_in;
   logic [VVW-1:0] top_low_ff, top_low_in, top_ord_ff, top_ord_in, from_ff, from_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] sts_ff;
   logic [VVW-1:0] rcomp_ff, rfrom_ff, rto_ff, rcount_ff;
   logic           cross_ff;

   logic           ld;
   logic [STS_W-1:0] ld_sts;
   logic [VVW-1:0] ld_comp, ld_from, ld_to;
   logic           out_free, last_sw;
   logic [VVW-1:0] w_val;
   logic [VAW-1:0] fr_v;
   logic [LW-1:0]  fr_link;
   logic [VVW-1:0] fr_low, fr_ord;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_done = (state_ff != S_INIT);
   assign last_sw   = (sw_ff == VAW'(MAX_VERTICES - 1));
   assign w_val     = etgt_rd_ff;
   assign {fr_v, fr_link, fr_low, fr_ord} = frame_rd_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      sw_in       = sw_ff;
      ent_in      = ent_ff;
      etotal_in   = etotal_ff;
      ts_in       = ts_ff;
      found_in    = found_ff;
      pdepth_in   = pdepth_ff;
      fdepth_in   = fdepth_ff;
      root_in     = root_ff;
      top_v_in    = top_v_ff;
      top_link_in = top_link_ff;
      top_low_in  = top_low_ff;
      top_ord_in  = top_ord_ff;
      from_in     = from_ff;
      q_pop   = 1'b0;
      ld      = 1'b0;
      ld_sts  = STS_OK;
      ld_comp = '0;
      ld_from = '0;
      ld_to   = '0;
      edge_we = 1'b0; elnk_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
      visit_we = 1'b0; comp_we = 1'b0; pend_we = 1'b0; frame_we = 1'b0;
      edge_re = 1'b0; vtx_re_head = 1'b0; vtx_re_visit = 1'b0; vtx_re_comp = 1'b0;
      pend_re = 1'b0; frame_re = 1'b0;
      edge_wa = EAW'(etotal_ff); elnk_wa = EAW'(etotal_ff); edge_ra = '0;
      head_wa = sw_ff; visit_wa = sw_ff; comp_wa = sw_ff; vtx_ra = '0;
      pend_wa = VAW'(pdepth_ff); pend_ra = VAW'(32'(pdepth_ff) - 32'd1);
      frame_wa = VAW'(32'(fdepth_ff) - 32'd1); frame_ra = VAW'(32'(fdepth_ff) - 32'd2);
      etgt_wd = VVW'(cur_ff.dst); esrc_wd = VVW'(cur_ff.src); elnk_wd = '0;
      head_wd = '0; visit_wd = '0; comp_wd = '0;
      pend_wd = ent_ff;
      frame_wd = {top_v_ff, top_link_ff, top_low_ff, top_ord_ff};

      case (state_ff)
         S_INIT: begin
            head_we = 1'b1;
            comp_we = 1'b1;
            sw_in = sw_ff + 1'b1;
            if (last_sw) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               sw_in  = '0;
               vtx_ra = VAW'(32'(q_item.src) - 32'd1);
               edge_ra = EAW'(q_item.idx);
               case (q_item.kind)
                  K_ADD: begin
                     if (q_item.bad_vertex) begin
                        ld = 1'b1; ld_sts = STS_RANGE;
                     end else if (32'(etotal_ff) >= MAX_EDGES) begin
                        ld = 1'b1; ld_sts = STS_FULL;
                     end else begin
                        vtx_re_head = 1'b1;
                        state_in = S_ADD2;
                     end
                  end
                  K_COMPUTE: state_in = S_CSWEEP;
                  K_QVERT: begin
                     if (q_item.bad_vertex) begin
                        ld = 1'b1; ld_sts = STS_RANGE;
                     end else begin
                        vtx_re_comp = 1'b1;
                        state_in = S_QV;
                     end
                  end
                  K_QEDGE: begin
                     if (32'(q_item.idx) >= 32'(etotal_ff)) begin
                        ld = 1'b1; ld_sts = STS_RANGE;
                     end else begin
                        edge_re = 1'b1;
                        state_in = S_QE1;
                     end
                  end
                  K_CLEAR: state_in = S_CLRSWEEP;
                  default: ld = 1'b1;
               endcase
            end
         end
         S_ADD2: begin
            edge_we = 1'b1;
            elnk_we = 1'b1;
            head_wa = VAW'(32'(cur_ff.src) - 32'd1);
            head_wd = LW'(32'(etotal_ff) + 32'd1);
            head_we = (head_rd_ff == '0);
            tail_we = 1'b1;
            etotal_in = LW'(32'(etotal_ff) + 32'd1);
            if (head_rd_ff == '0) begin
               ld = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_ADD3;
            end
         end
         S_ADD3: begin
            // append to the old tail's link
            elnk_we = 1'b1;
            elnk_wa = EAW'(32'(tail_rd_ff) - 32'd1);
            elnk_wd = etotal_ff;
            ld = 1'b1;
            state_in = S_IDLE;
         end
         S_QV: begin
            ld = 1'b1;
            ld_comp = comp_rd_ff;
            state_in = S_IDLE;
         end
         S_QE1: begin
            vtx_re_comp = 1'b1;
            vtx_ra = VAW'(32'(esrc_rd_ff) - 32'd1);
            state_in = S_QE2;
         end
         S_QE2: begin
            from_in = comp_rd_ff;
            vtx_re_comp = 1'b1;
            vtx_ra = VAW'(32'(etgt_rd_ff) - 32'd1);
            state_in = S_QE3;
         end
         S_QE3: begin
            ld = 1'b1;
            ld_from = from_ff;
            ld_to = comp_rd_ff;
            state_in = S_IDLE;
         end
         S_CLRSWEEP: begin
            head_we = 1'b1;
            sw_in = sw_ff + 1'b1;
            if (last_sw) begin
               etotal_in = '0;
               ld = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CSWEEP: begin
            visit_we = 1'b1;
            comp_we = 1'b1;
            sw_in = sw_ff + 1'b1;
            if (last_sw) begin
               ts_in = '0;
               found_in = '0;
               pdepth_in = '0;
               fdepth_in = '0;
               root_in = RW'(1);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            vtx_ra = VAW'(32'(root_ff) - 32'd1);
            if (32'(root_ff) > 32'(active_n)) begin
               ld = 1'b1;
               state_in = S_IDLE;
            end else begin
               vtx_re_visit = 1'b1;
               state_in = S_ROOTCHK;
            end
         end
         S_ROOTCHK: begin
            vtx_ra = VAW'(32'(root_ff) - 32'd1);
            if (visit_rd_ff != '0) begin
               root_in = root_ff + 1'b1;
               state_in = S_ROOT;
            end else begin
               ent_in = vtx_ra;
               vtx_re_head = 1'b1;
               state_in = S_ENTER;
            end
         end
         S_ENTER: begin
            pend_we = 1'b1;
            pdepth_in = pdepth_ff + 1'b1;
            ts_in = ts_ff + 1'b1;
            visit_we = 1'b1;
            visit_wa = ent_ff;
            visit_wd = ts_in;
            frame_we = (fdepth_ff != '0);
            fdepth_in = fdepth_ff + 1'b1;
            top_v_in = ent_ff;
            top_link_in = head_rd_ff;
            top_low_in = ts_in;
            top_ord_in = ts_in;
            state_in = S_STEP;
         end
         S_STEP: begin
            edge_ra = EAW'(32'(top_link_ff) - 32'd1);
            if (top_link_ff != '0) begin
               edge_re = 1'b1;
               state_in = S_EDGE;
            end else if (top_low_ff == top_ord_ff) begin
               found_in = found_ff + 1'b1;
               pend_re = 1'b1;
               state_in = S_POPD;
            end else begin
               state_in = S_RET;
            end
         end
         S_EDGE: begin
            top_link_in = elnk_rd_ff;
            vtx_ra = VAW'(32'(w_val) - 32'd1);
            if (w_val == '0 || 32'(w_val) > 32'(active_n)) begin
               state_in = S_STEP;
            end else begin
               ent_in = vtx_ra;
               vtx_re_visit = 1'b1;
               vtx_re_comp = 1'b1;
               state_in = S_VIS;
            end
         end
         S_VIS: begin
            vtx_ra = ent_ff;
            if (visit_rd_ff == '0) begin
               vtx_re_head = 1'b1;
               state_in = S_ENTER;
            end else begin
               if (comp_rd_ff == '0 && visit_rd_ff < top_low_ff) top_low_in = visit_rd_ff;
               state_in = S_STEP;
            end
         end
         S_POPD: begin
            comp_we = 1'b1;
            comp_wa = pend_rd_ff;
            comp_wd = found_ff;
            pdepth_in = pdepth_ff - 1'b1;
            pend_ra = VAW'(32'(pdepth_ff) - 32'd2);
            if (pend_rd_ff == top_v_ff || pdepth_ff == VVW'(1)) begin
               state_in = S_RET;
            end else begin
               pend_re = 1'b1;
            end
         end
         S_RET: begin
            if (fdepth_ff == VVW'(1)) begin
               fdepth_in = '0;
               root_in = root_ff + 1'b1;
               state_in = S_ROOT;
            end else begin
               frame_re = 1'b1;
               fdepth_in = fdepth_ff - 1'b1;
               state_in = S_RET2;
            end
         end
         S_RET2: begin
            top_v_in = fr_v;
            top_link_in = fr_link;
            top_ord_in = fr_ord;
            top_low_in = (top_low_ff < fr_low) ? top_low_ff : fr_low;
            state_in = S_STEP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ld) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sw_ff        <= '0;
         etotal_ff    <= '0;
         found_ff     <= '0;
         ts_ff        <= '0;
         pdepth_ff    <= '0;
         fdepth_ff    <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         etotal_ff    <= etotal_in;
         found_ff     <= found_in;
         ts_ff        <= ts_in;
         pdepth_ff    <= pdepth_in;
         fdepth_ff    <= fdepth_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      ent_ff      <= ent_in;
      top_v_ff    <= top_v_in;
      top_link_ff <= top_link_in;
      top_low_ff  <= top_low_in;
      top_ord_ff  <= top_ord_in;
      from_ff     <= from_in;
      if (ld) begin
         sts_ff    <= ld_sts;
         rcomp_ff  <= ld_comp;
         rfrom_ff  <= ld_from;
         rto_ff    <= ld_to;
         cross_ff  <= (ld_from != '0) && (ld_to != '0) && (ld_from != ld_to);
         rcount_ff <= found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         etgt_mem[edge_wa] <= etgt_wd;
         esrc_mem[edge_wa] <= esrc_wd;
      end
      if (edge_re) begin
         etgt_rd_ff <= etgt_mem[edge_ra];
         esrc_rd_ff <= esrc_mem[edge_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (elnk_we) elnk_mem[elnk_wa] <= elnk_wd;
      if (edge_re) elnk_rd_ff <= elnk_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (vtx_re_head) head_rd_ff <= head_mem[vtx_ra];
   end

   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[head_wa] <= head_wd;
      if (vtx_re_head) tail_rd_ff <= tail_mem[vtx_ra];
   end

   always_ff @(posedge clock) begin
      if (visit_we) visit_mem[visit_wa] <= visit_wd;
      if (vtx_re_visit) visit_rd_ff <= visit_mem[vtx_ra];
   end

   always_ff @(posedge clock) begin
      if (comp_we) comp_mem[comp_wa] <= comp_wd;
      if (vtx_re_comp) comp_rd_ff <= comp_mem[vtx_ra];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      if (pend_re) pend_rd_ff <= pend_mem[pend_ra];
   end

   always_ff @(posedge clock) begin
      if (frame_we) frame_mem[frame_wa] <= frame_wd;
      if (frame_re) frame_rd_ff <= frame_mem[frame_ra];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = sts_ff;
   assign rsp_component       = VTX_W'(rcomp_ff);
   assign rsp_from_component  = VTX_W'(rfrom_ff);
   assign rsp_to_component    = VTX_W'(rto_ff);
   assign rsp_crosses         = cross_ff;
   assign rsp_component_count = VTX_W'(rcount_ff);

endmodule

@@ design/strongly_connected_components_core.sv @@
// Top level of the strongly connected components core (Tarjan).
// Depends on scc_pkg, scc_front, scc_queue and scc_back.
//
//   channel | ports        | handshake
//   --------+--------------+------------------------------
//   request | req_*        | req_valid / req_ready
//   result  | rsp_*        | rsp_valid / rsp_ready
//   config  | csr_write_*  | write enable, no wait
//
// Compute runs a clearing sweep over the vertex store, then root checks, edge
// visits, vertex entries, stack pops and returns. Clear zeroes every edge-list head.
// After reset a clearing pass runs with req_ready low. A two-entry queue keeps
// taking transactions while a result waits on rsp_ready.
module strongly_connected_components_core #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [scc_pkg::VTX_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [scc_pkg::OP_W-1:0]      req_op,
   input  logic [scc_pkg::VTX_W-1:0]     req_source_vertex,
   input  logic [scc_pkg::VTX_W-1:0]     req_target_vertex,
   input  logic [scc_pkg::IDX_W-1:0]     req_edge_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [scc_pkg::STS_W-1:0]     rsp_status,
   output logic [scc_pkg::VTX_W-1:0]     rsp_component,
   output logic [scc_pkg::VTX_W-1:0]     rsp_from_component,
   output logic [scc_pkg::VTX_W-1:0]     rsp_to_component,
   output logic                          rsp_crosses,
   output logic [scc_pkg::VTX_W-1:0]     rsp_component_count
);
   import scc_pkg::*;

   localparam int VVW = $clog2(MAX_VERTICES + 1);

   item_type       front_item, head_item;
   logic [VVW-1:0] active_n;
   logic           q_not_full, q_not_empty, q_pop, init_done;

   assign req_ready = q_not_full && init_done;

   scc_front #(.MAX_VERTICES(MAX_VERTICES), .VVW(VVW)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_op            (req_op),
      .req_source_vertex (req_source_vertex),
      .req_target_vertex (req_target_vertex),
      .req_edge_index    (req_edge_index),
      .item              (front_item),
      .active_n          (active_n)
   );

   scc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_item (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   scc_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .VVW(VVW)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_not_empty),
      .q_item              (head_item),
      .q_pop               (q_pop),
      .active_n            (active_n),
      .init_done           (init_done),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_component       (rsp_component),
      .rsp_from_component  (rsp_from_component),
      .rsp_to_component    (rsp_to_component),
      .rsp_crosses         (rsp_crosses),
      .rsp_component_count (rsp_component_count)
   );

endmodule
